FILE: hw/rtl/fifo_page_replacement_core_assert.svh
// Assertion macros shared by the page replacement core checkers.
`ifndef FIFO_PAGE_REPLACEMENT_CORE_ASSERT_SVH
`define FIFO_PAGE_REPLACEMENT_CORE_ASSERT_SVH

// Condition holds in one cycle, consequence must hold in the next.
`define FPR_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Condition implies consequence in the same cycle.
`define FPR_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/fpr_pkg.sv
// Shared types and constants for the FIFO page replacement core.
package fpr_pkg;

   localparam int PAGE_WIDTH  = 16;
   localparam int COUNT_WIDTH = 16;
   localparam int CFG_WIDTH   = 4;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // Frame count register value after reset
   localparam logic [CFG_WIDTH-1:0] CFG_RESET_FRAMES = 4'd8;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic take;     // an item is accepted this cycle
      logic fill;     // miss with a free frame: append the page
      logic replace;  // miss with all frames full: evict the oldest
      logic flush;    // frame count rewritten: drop resident pages
   } fpr_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic hit;        // incoming page matches a resident frame
      logic last_free;  // exactly one free frame is left
   } fpr_status_type;

endpackage

FILE: hw/rtl/fpr_ctrl.sv
// Controller: tracks filling versus full and issues per-item commands.
module fpr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   csr_write_enable,
   input  fpr_pkg::fpr_status_type status,
   output fpr_pkg::fpr_cmd_type   cmd
);
   import fpr_pkg::*;

   localparam logic ST_FILLING = 1'b0;
   localparam logic ST_FULL    = 1'b1;

   logic state_ff;
   logic state_in;
   logic take;
   logic miss;

   assign take = start && !reset;
   assign miss = take && !status.hit;

   // Command decode
   always_comb begin
      cmd         = '0;
      cmd.take    = take;
      cmd.flush   = csr_write_enable;
      unique case (state_ff)
         ST_FILLING: cmd.fill    = miss;
         ST_FULL:    cmd.replace = miss;
         default:    cmd.fill    = miss;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      if (csr_write_enable) begin
         state_in = ST_FILLING;
      end else if (state_ff == ST_FILLING && miss && status.last_free) begin
         state_in = ST_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILLING;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/fpr_datapath.sv
// Datapath: frame registers, lookup, ring pointer, counters and result registers.
module fpr_datapath #(
   parameter int FRAMES    = 8,
   parameter int PAGE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [fpr_pkg::PAGE_WIDTH-1:0]       req_page_number,
   input  logic [fpr_pkg::CFG_WIDTH-1:0]        csr_write_data,
   input  fpr_pkg::fpr_cmd_type                 cmd,
   output fpr_pkg::fpr_status_type              status,
   output logic                                 rsp_valid,
   output logic                                 rsp_hit,
   output logic                                 rsp_victim_valid,
   output logic [fpr_pkg::PAGE_WIDTH-1:0]       rsp_victim_page,
   output logic [fpr_pkg::COUNT_WIDTH-1:0]      rsp_fault_count,
   output logic [fpr_pkg::COUNT_WIDTH-1:0]      rsp_access_count
);
   import fpr_pkg::*;

   // The 4-bit frame count caps the usable frames at 15
   localparam int CFG_MAX = (1 << CFG_WIDTH) - 1;
   localparam int SLOTS   = (FRAMES < CFG_MAX) ? FRAMES : CFG_MAX;
   localparam int SB      = (PAGE_BITS < PAGE_WIDTH) ? PAGE_BITS : PAGE_WIDTH;
   localparam int AW      = $clog2(SLOTS + 1);
   localparam int PW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int RESET_ACTIVE =
      (int'(CFG_RESET_FRAMES) > SLOTS) ? SLOTS : int'(CFG_RESET_FRAMES);

   logic [SB-1:0]          frame_ff [SLOTS];
   logic [AW-1:0]          count_ff;
   logic [AW-1:0]          count_in;
   logic [PW-1:0]          ptr_ff;
   logic [PW-1:0]          ptr_in;
   logic [AW-1:0]          active_ff;
   logic [AW-1:0]          active_in;
   logic [COUNT_WIDTH-1:0] faults_ff;
   logic [COUNT_WIDTH-1:0] faults_in;
   logic [COUNT_WIDTH-1:0] refs_ff;
   logic [COUNT_WIDTH-1:0] refs_in;

   logic                   valid_ff;
   logic                   hit_ff;
   logic                   victim_valid_ff;
   logic [SB-1:0]          victim_ff;

   logic [SB-1:0]          page;
   logic                   hit;
   logic                   wr_en;
   logic [PW-1:0]          wr_idx;

   assign page = req_page_number[SB-1:0];

   // Parallel compare against resident frames
   always_comb begin
      hit = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (AW'(i) < count_ff && frame_ff[i] == page) begin
            hit = 1'b1;
         end
      end
   end

   assign status.hit       = hit;
   assign status.last_free = ({1'b0, count_ff} + (AW + 1)'(1)) == {1'b0, active_ff};

   // Frame write port: next free slot on fill, oldest slot on replace
   assign wr_en  = cmd.fill || cmd.replace;
   assign wr_idx = cmd.fill ? count_ff[PW-1:0] : ptr_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         if (wr_en && wr_idx == PW'(i)) begin
            frame_ff[i] <= page;
         end
      end
   end

   // Clamp of the written frame count
   always_comb begin
      if (csr_write_data == '0) begin
         active_in = AW'(1);
      end else if (int'(csr_write_data) > SLOTS) begin
         active_in = AW'(SLOTS);
      end else begin
         active_in = csr_write_data[AW-1:0];
      end
   end

   // Fill count, ring pointer and saturating counters
   always_comb begin
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      faults_in = faults_ff;
      refs_in   = refs_ff;
      if (cmd.flush) begin
         count_in = '0;
         ptr_in   = '0;
      end else begin
         if (cmd.fill) begin
            count_in = count_ff + AW'(1);
         end
         if (cmd.replace) begin
            if ((AW'(ptr_ff) + AW'(1)) == active_ff) begin
               ptr_in = '0;
            end else begin
               ptr_in = ptr_ff + PW'(1);
            end
         end
      end
      if (cmd.take) begin
         if (refs_ff != COUNT_MAX) begin
            refs_in = refs_ff + COUNT_WIDTH'(1);
         end
         if (!hit && faults_ff != COUNT_MAX) begin
            faults_in = faults_ff + COUNT_WIDTH'(1);
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         ptr_ff    <= '0;
         active_ff <= AW'(RESET_ACTIVE);
         faults_ff <= '0;
         refs_ff   <= '0;
         valid_ff  <= 1'b0;
      end else begin
         count_ff  <= count_in;
         ptr_ff    <= ptr_in;
         faults_ff <= faults_in;
         refs_ff   <= refs_in;
         valid_ff  <= cmd.take;
         if (cmd.flush) begin
            active_ff <= active_in;
         end
      end
   end

   // Result payload registers
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         hit_ff          <= hit;
         victim_valid_ff <= cmd.replace;
         victim_ff       <= cmd.replace ? frame_ff[ptr_ff] : '0;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_hit          = hit_ff;
   assign rsp_victim_valid = victim_valid_ff;
   assign rsp_victim_page  = PAGE_WIDTH'(victim_ff);
   assign rsp_fault_count  = faults_ff;
   assign rsp_access_count = refs_ff;

endmodule

FILE: hw/rtl/fifo_page_replacement_core.sv
// Top level of the FIFO page replacement core.
//
// Usage:
//   Request: drive req_page_number and raise start. The item is taken at a
//   clock edge where start is high and busy is low. busy is high only while
//   reset is applied, so one reference can be taken every cycle.
//   Response: in the cycle after an item is taken, rsp_valid pulses for one
//   cycle with hit, victim_valid, victim_page and the saturating fault and
//   access counts. Throughput is 1 item per cycle, set by the combinational
//   compare against all resident frames and the ring pointer update.
//   Configuration: csr_write_enable with csr_write_data sets the number of
//   active frames (0 reads as 1, values above the frame store are clipped).
//   Every write drops all resident pages; the counters are kept. Write only
//   while no item is in flight.
//   Reset: synchronous; clears the resident pages, the pointer, both counts
//   and selects 8 active frames, or all if fewer. The receiver cannot stall:
//   each result is shown for exactly one cycle.
module fifo_page_replacement_core #(
   parameter int FRAMES    = 8,
   parameter int PAGE_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [fpr_pkg::PAGE_WIDTH-1:0]   req_page_number,
   input  logic                             csr_write_enable,
   input  logic [fpr_pkg::CFG_WIDTH-1:0]    csr_write_data,
   output logic                             rsp_valid,
   output logic                             rsp_hit,
   output logic                             rsp_victim_valid,
   output logic [fpr_pkg::PAGE_WIDTH-1:0]   rsp_victim_page,
   output logic [fpr_pkg::COUNT_WIDTH-1:0]  rsp_fault_count,
   output logic [fpr_pkg::COUNT_WIDTH-1:0]  rsp_access_count
);
   import fpr_pkg::*;

   fpr_cmd_type    cmd;
   fpr_status_type status;

   assign busy = reset;

   fpr_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .csr_write_enable (csr_write_enable),
      .status           (status),
      .cmd              (cmd)
   );

   fpr_datapath #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_page_number  (req_page_number),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_victim_valid (rsp_victim_valid),
      .rsp_victim_page  (rsp_victim_page),
      .rsp_fault_count  (rsp_fault_count),
      .rsp_access_count (rsp_access_count)
   );

endmodule

FILE: hw/rtl/fpr_checker.sv
// Port-level checker for the FIFO page replacement core, with its bind.
`include "fifo_page_replacement_core_assert.svh"

module fpr_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_hit,
   input logic        rsp_victim_valid,
   input logic [15:0] rsp_victim_page,
   input logic [15:0] rsp_fault_count,
   input logic [15:0] rsp_access_count
);

   // Every taken item answers in the next cycle, and only then
   `FPR_ASSERT_NEXT(a_rsp_follows, clock, reset, start && !busy, rsp_valid, "missing response")
   `FPR_ASSERT_NEXT(a_no_spurious, clock, reset, !(start && !busy), !rsp_valid, "extra response")

   // A hit never evicts
   `FPR_ASSERT_SAME(a_hit_no_victim, clock, reset, rsp_valid && rsp_hit, !rsp_victim_valid, "hit evicted")

   // No eviction means a zero victim field
   `FPR_ASSERT_SAME(a_victim_zero, clock, reset, rsp_valid && !rsp_victim_valid, rsp_victim_page == 16'd0, "stale victim page")

   // Faults can never outnumber references
   `FPR_ASSERT_SAME(a_count_order, clock, reset, rsp_valid, rsp_fault_count <= rsp_access_count, "fault count above access count")

endmodule

bind fifo_page_replacement_core fpr_checker u_fpr_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_hit          (rsp_hit),
   .rsp_victim_valid (rsp_victim_valid),
   .rsp_victim_page  (rsp_victim_page),
   .rsp_fault_count  (rsp_fault_count),
   .rsp_access_count (rsp_access_count)
);

FILE: dv/fifo_page_replacement_core_tb.sv
// Self-checking testbench for the FIFO page replacement core.
`timescale 1ns / 1ps

typedef struct packed {
   logic                               hit;
   logic                               victim_valid;
   logic [fpr_pkg::PAGE_WIDTH-1:0]     victim_page;
   logic [fpr_pkg::COUNT_WIDTH-1:0]    fault_count;
   logic [fpr_pkg::COUNT_WIDTH-1:0]    access_count;
} page_result_type;

// Tracks resident pages, predicts each reference outcome and checks results
class page_fifo_scoreboard;
   localparam int NUM_FRAMES = 8;

   logic [fpr_pkg::PAGE_WIDTH-1:0]  frame_q [NUM_FRAMES];
   int unsigned                     resident;
   int unsigned                     oldest;
   logic [fpr_pkg::COUNT_WIDTH-1:0] faults;
   logic [fpr_pkg::COUNT_WIDTH-1:0] refs;
   logic [fpr_pkg::CFG_WIDTH-1:0]   frames_cfg;
   page_result_type                 expected_q [$];
   int                              failures;

   function new();
      resident   = 0;
      oldest     = 0;
      faults     = '0;
      refs       = '0;
      frames_cfg = fpr_pkg::CFG_RESET_FRAMES;
      failures   = 0;
   endfunction

   // Frame count write: resident pages dropped, counters kept
   function void set_frames(logic [fpr_pkg::CFG_WIDTH-1:0] v);
      frames_cfg = v;
      resident   = 0;
      oldest     = 0;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   // Predict the outcome of one accepted reference
   function void note_reference(logic [fpr_pkg::PAGE_WIDTH-1:0] page);
      page_result_type r;
      int unsigned     n;
      bit              found;
      n = (frames_cfg == 0) ? 1 : ((frames_cfg > NUM_FRAMES) ? NUM_FRAMES : frames_cfg);
      if (resident > n) resident = n;
      if (oldest >= n) oldest = 0;
      found = 1'b0;
      for (int i = 0; i < resident; i++) begin
         if (frame_q[i] == page) found = 1'b1;
      end
      r = '0;
      r.hit = found;
      if (!found) begin
         if (resident < n) begin
            frame_q[resident] = page;
            resident++;
         end else begin
            r.victim_valid  = 1'b1;
            r.victim_page   = frame_q[oldest];
            frame_q[oldest] = page;
            oldest          = (oldest + 1 >= n) ? 0 : oldest + 1;
         end
         if (faults != fpr_pkg::COUNT_MAX) faults++;
      end
      if (refs != fpr_pkg::COUNT_MAX) refs++;
      r.fault_count  = faults;
      r.access_count = refs;
      expected_q.push_back(r);
   endfunction

   // Compare one result with the oldest prediction
   function void check_result(page_result_type got);
      page_result_type want;
      if (expected_q.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("unexpected result: hit=%0b vv=%0b victim=%h faults=%h refs=%h",
                     got.hit, got.victim_valid, got.victim_page,
                     got.fault_count, got.access_count);
         return;
      end
      want = expected_q.pop_front();
      if (got.hit !== want.hit || got.victim_valid !== want.victim_valid ||
          got.victim_page !== want.victim_page || got.fault_count !== want.fault_count ||
          got.access_count !== want.access_count) begin
         failures++;
         if (failures <= 10) begin
            $display("mismatch: exp hit=%0b vv=%0b victim=%h faults=%h refs=%h",
                     want.hit, want.victim_valid, want.victim_page, want.fault_count,
                     want.access_count);
            $display("          got hit=%0b vv=%0b victim=%h faults=%h refs=%h",
                     got.hit, got.victim_valid, got.victim_page,
                     got.fault_count, got.access_count);
         end
      end
   endfunction
endclass

module fifo_page_replacement_core_tb;
   localparam int CYCLE_LIMIT = 2000000;

   logic                              clock;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic [fpr_pkg::PAGE_WIDTH-1:0]    req_page_number;
   logic                              csr_write_enable;
   logic [fpr_pkg::CFG_WIDTH-1:0]     csr_write_data;
   logic                              rsp_valid;
   logic                              rsp_hit;
   logic                              rsp_victim_valid;
   logic [fpr_pkg::PAGE_WIDTH-1:0]    rsp_victim_page;
   logic [fpr_pkg::COUNT_WIDTH-1:0]   rsp_fault_count;
   logic [fpr_pkg::COUNT_WIDTH-1:0]   rsp_access_count;

   page_fifo_scoreboard sb;
   int                  idle_pct;
   int                  chunk;
   int                  cycle_count;

   fifo_page_replacement_core #(
      .FRAMES    (8),
      .PAGE_BITS (16)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_page_number  (req_page_number),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_victim_valid (rsp_victim_valid),
      .rsp_victim_page  (rsp_victim_page),
      .rsp_fault_count  (rsp_fault_count),
      .rsp_access_count (rsp_access_count)
   );

   always #5 clock = ~clock;

   // Result monitor: values sampled before this edge's updates
   always @(posedge clock) begin
      page_result_type got;
      if (!reset && rsp_valid) begin
         got.hit          = rsp_hit;
         got.victim_valid = rsp_victim_valid;
         got.victim_page  = rsp_victim_page;
         got.fault_count  = rsp_fault_count;
         got.access_count = rsp_access_count;
         sb.check_result(got);
      end
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // Present one reference and hold it until the core takes it
   task automatic send_page(input logic [fpr_pkg::PAGE_WIDTH-1:0] pg);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_page_number <= pg;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_reference(pg);
   endtask

   // Frame count write, only once every pending result is back
   task automatic write_frames(input logic [fpr_pkg::CFG_WIDTH-1:0] v);
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_frames(v);
   endtask

   // Random references drawn mostly from a small page pool so hits occur
   task automatic random_phase(input int n_items, input int pct);
      int                             done;
      int                             span;
      logic [fpr_pkg::PAGE_WIDTH-1:0] base;
      logic [fpr_pkg::PAGE_WIDTH-1:0] pg;
      idle_pct = pct;
      done     = 0;
      while (done < n_items) begin
         write_frames(fpr_pkg::CFG_WIDTH'((chunk * 7) % 16));
         chunk++;
         base = fpr_pkg::PAGE_WIDTH'($urandom);
         span = $urandom_range(2, 11);
         repeat ($urandom_range(25, 45)) begin
            if ($urandom_range(9) == 0)
               pg = fpr_pkg::PAGE_WIDTH'($urandom);
            else
               pg = base + fpr_pkg::PAGE_WIDTH'($urandom_range(0, span));
            send_page(pg);
            done++;
         end
      end
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      start            = 1'b0;
      req_page_number  = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      idle_pct         = 0;
      chunk            = 0;
      sb               = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, fill, eviction at reset frame count
      send_page(16'h0000);
      send_page(16'hFFFF);
      send_page(16'h0000);
      send_page(16'hFFFF);
      for (int p = 1; p <= 6; p++) send_page(fpr_pkg::PAGE_WIDTH'(p));
      send_page(16'h0007);
      send_page(16'h0000);
      send_page(16'hAAAA);
      send_page(16'h5555);

      // Zero frame count acts as one frame; the write flushes residents
      write_frames(4'd0);
      send_page(16'h0003);
      send_page(16'h0003);
      send_page(16'h0004);
      send_page(16'h0003);

      // Oversized frame counts clip to the store size
      write_frames(4'd15);
      for (int p = 0; p < 10; p++) send_page(fpr_pkg::PAGE_WIDTH'(p % 9));
      write_frames(4'd9);
      send_page(16'h0001);

      // Random phases: sender idling 14%, then 56%, then none
      random_phase(220, 14);
      random_phase(220, 56);
      random_phase(220, 0);

      // Drain
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (sb.failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
